// ----- sv/xcs_pkg.sv -----
// shared types, constants and functions of the xmodem crc sender
`default_nettype none
package xcs_pkg;

  localparam int unsigned MaxBlockBytes = 1024;
  localparam int unsigned FifoDepth     = 4;

  localparam logic [7:0] BSoh = 8'h01;
  localparam logic [7:0] BStx = 8'h02;
  localparam logic [7:0] BEot = 8'h04;
  localparam logic [7:0] BAck = 8'h06;
  localparam logic [7:0] BNak = 8'h15;
  localparam logic [7:0] BCan = 8'h18;
  localparam logic [7:0] BC   = 8'h43;
  localparam logic [7:0] BK   = 8'h4b;

  typedef enum logic [2:0] {
    OpFile  = 3'd0,
    OpLine  = 3'd1,
    OpTmo   = 3'd2,
    OpSlot  = 3'd3,
    OpStart = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    PhSync  = 3'd0,
    PhKwait = 3'd1,
    PhFill  = 3'd2,
    PhSend  = 3'd3,
    PhWait  = 3'd4,
    PhDone  = 3'd5,
    PhFail  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KNone  = 3'd0,
    KByte  = 3'd1,
    KData  = 3'd2,
    KSum   = 3'd3,
    KCrcHi = 3'd4,
    KCrcLo = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    RegSyncTry = 2'd0,
    RegRetry   = 2'd1,
    RegAckRead = 2'd2,
    RegEotTry  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       need_data;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sync_try_limit;
    logic [7:0] retry_limit;
    logic [7:0] ack_read_limit;
    logic [7:0] eot_try_limit;
  } cfg_t;

  // one command for the back end
  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_val;
    logic       clr;
    logic       need_data;
    logic [1:0] status;
  } cmd_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/xcs_ram.sv -----
// generic ram with one write port, one read port and registered read
`default_nettype none
module xcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- sv/xcs_front.sv -----
// front end: protocol sequencer, packet store and command issue
`default_nettype none
module xcs_front #(
  parameter int unsigned MaxBlockBytes = xcs_pkg::MaxBlockBytes
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xcs_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire xcs_pkg::in_item_t in_data_i,
  input  wire logic [2:0]        fifo_cnt_i,
  output logic                   push_o,
  output xcs_pkg::cmd_t          push_cmd_o
);
  import xcs_pkg::*;

  localparam int unsigned AW = $clog2(MaxBlockBytes);

  phase_e      phase_q, phase_d;
  logic [10:0] fill_q, fill_d, send_q, send_d;
  logic [7:0]  blk_q, blk_d, try_q, try_d, rc_q, rc_d;
  logic        long_q, long_d, sum_q, sum_d, eof_q, eof_d;
  logic        s1_v_q;
  cmd_t        s1_q, cmd;
  logic        pad_q, pad;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  rdata;
  logic        acc;
  logic [10:0] len, last, d;
  logic        at_eot, failed;
  logic [7:0]  rc_b, try_b, lim;
  logic [2:0]  pending;

  assign pending    = fifo_cnt_i + {2'b00, s1_v_q};
  assign in_ready_o = pending < 3'(FifoDepth);
  assign acc        = in_valid_i && in_ready_o;

  assign len    = long_q ? 11'd1024 : 11'd128;
  assign last   = 11'd3 + len + (sum_q ? 11'd0 : 11'd1);
  assign d      = send_q - 11'd3;
  assign at_eot = eof_q && (fill_q == 11'd0);
  assign rc_b   = (rc_q == 8'd255) ? rc_q : rc_q + 8'd1;
  assign try_b  = (try_q == 8'd255) ? try_q : try_q + 8'd1;
  assign lim    = at_eot ? cfg_i.eot_try_limit : cfg_i.retry_limit;

  always_comb begin
    phase_d = phase_q; fill_d = fill_q; send_d = send_q; blk_d = blk_q;
    try_d = try_q; rc_d = rc_q; long_d = long_q; sum_d = sum_q; eof_d = eof_q;
    cmd.kind = KNone; cmd.byte_val = 8'h00; cmd.clr = 1'b0;
    pad = 1'b0; we = 1'b0; failed = 1'b0;
    waddr = fill_q[AW-1:0];
    raddr = d[AW-1:0];
    if (in_data_i.operation == OpStart) begin
      phase_d = PhSync; fill_d = '0; send_d = '0; blk_d = 8'd1;
      try_d = '0; rc_d = '0; long_d = 1'b0; sum_d = 1'b0; eof_d = 1'b0;
      cmd.clr = 1'b1;
    end else if (in_data_i.operation == OpFile && phase_q == PhFill) begin
      we     = fill_q < 11'(MaxBlockBytes);
      fill_d = fill_q + 11'd1;
      if (in_data_i.end_of_file) eof_d = 1'b1;
      if (in_data_i.end_of_file || fill_d >= len) begin
        phase_d = PhSend; send_d = '0; cmd.clr = 1'b1;
      end
    end else if ((in_data_i.operation == OpLine || in_data_i.operation == OpTmo)
                 && phase_q == PhSync) begin
      rc_d = rc_b;
      if (in_data_i.operation == OpLine && in_data_i.data_byte == BNak) begin
        sum_d = 1'b1; long_d = 1'b0; fill_d = '0; phase_d = PhFill;
      end else if (in_data_i.operation == OpLine && in_data_i.data_byte == BC) begin
        sum_d = 1'b0; phase_d = PhKwait;
      end else if (rc_b >= cfg_i.sync_try_limit) begin
        phase_d = PhFail;
      end
    end else if ((in_data_i.operation == OpLine || in_data_i.operation == OpTmo)
                 && phase_q == PhKwait) begin
      long_d  = in_data_i.operation == OpLine && in_data_i.data_byte == BK
                && MaxBlockBytes >= 1024;
      fill_d  = '0;
      phase_d = PhFill;
    end else if ((in_data_i.operation == OpLine || in_data_i.operation == OpTmo)
                 && phase_q == PhWait) begin
      rc_d = rc_b;
      if (in_data_i.operation == OpLine && in_data_i.data_byte == BAck) begin
        try_d = '0;
        if (at_eot) phase_d = PhDone;
        else begin
          blk_d = blk_q + 8'd1; fill_d = '0;
          if (eof_q) begin
            phase_d = PhSend; send_d = '0; cmd.clr = 1'b1;
          end else phase_d = PhFill;
        end
      end else if (in_data_i.operation == OpLine && (in_data_i.data_byte == BNak
                   || in_data_i.data_byte == BC || in_data_i.data_byte == BCan)) begin
        failed = 1'b1;
      end else if (rc_b >= cfg_i.ack_read_limit) begin
        failed = 1'b1;
      end
      if (failed) begin
        try_d = try_b;
        if (try_b >= lim) phase_d = PhFail;
        else begin
          phase_d = PhSend; send_d = '0; cmd.clr = 1'b1;
        end
      end
    end else if (in_data_i.operation == OpSlot && phase_q == PhSend) begin
      if (at_eot) begin
        cmd.kind = KByte; cmd.byte_val = BEot; phase_d = PhWait; rc_d = '0;
      end else begin
        if (send_q == 11'd0) begin
          cmd.kind = KByte; cmd.byte_val = long_q ? BStx : BSoh;
        end else if (send_q == 11'd1) begin
          cmd.kind = KByte; cmd.byte_val = blk_q;
        end else if (send_q == 11'd2) begin
          cmd.kind = KByte; cmd.byte_val = ~blk_q;
        end else if (send_q < 11'd3 + len) begin
          cmd.kind = KData; pad = !(d < fill_q);
        end else if (sum_q) begin
          cmd.kind = KSum;
        end else if (send_q == 11'd3 + len) begin
          cmd.kind = KCrcHi;
        end else begin
          cmd.kind = KCrcLo;
        end
        if (send_q >= last) begin
          phase_d = PhWait; rc_d = '0;
        end else send_d = send_q + 11'd1;
      end
    end
    cmd.need_data = phase_d == PhFill;
    cmd.status    = (phase_d == PhDone) ? 2'd1 : ((phase_d == PhFail) ? 2'd2 : 2'd0);
  end

  xcs_ram #(.Width(8), .Depth(MaxBlockBytes)) u_store (
    .clk_i,
    .we_i    (acc && we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.data_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSync; fill_q <= '0; send_q <= '0; blk_q <= 8'd1;
      try_q <= '0; rc_q <= '0; long_q <= 1'b0; sum_q <= 1'b0; eof_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc;
      if (acc) begin
        phase_q <= phase_d; fill_q <= fill_d; send_q <= send_d; blk_q <= blk_d;
        try_q <= try_d; rc_q <= rc_d; long_q <= long_d; sum_q <= sum_d;
        eof_q <= eof_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q  <= cmd;
      pad_q <= pad;
    end
  end

  // store data lands in the cycle after the read, together with the registered command
  always_comb begin
    push_cmd_o = s1_q;
    if (s1_q.kind == KData) push_cmd_o.byte_val = pad_q ? 8'h00 : rdata;
  end
  assign push_o = s1_v_q;
endmodule
`default_nettype wire

// ----- sv/xcs_back.sv -----
// back end: command queue, check accumulators and output register
`default_nettype none
module xcs_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire xcs_pkg::cmd_t      push_cmd_i,
  output logic [2:0]              fifo_cnt_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output xcs_pkg::out_item_t      out_data_o
);
  import xcs_pkg::*;

  cmd_t        fifo_q [FifoDepth];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  logic        pop;
  cmd_t        head;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  sum_q, sum_d;
  out_item_t   res, out_q;
  logic        out_v_q;

  assign head       = fifo_q[rp_q];
  assign pop        = (cnt_q != 3'd0) && (!out_v_q || out_ready_i);
  assign fifo_cnt_o = cnt_q;

  always_comb begin
    crc_d = crc_q; sum_d = sum_q;
    res.tx_valid  = head.kind != KNone;
    res.need_data = head.need_data;
    res.status    = head.status;
    case (head.kind)
      KSum:    res.tx_byte = sum_q;
      KCrcHi:  res.tx_byte = crc_q[15:8];
      KCrcLo:  res.tx_byte = crc_q[7:0];
      KNone:   res.tx_byte = 8'h00;
      default: res.tx_byte = head.byte_val;
    endcase
    if (head.kind == KData) begin
      crc_d = crc_byte(crc_q, head.byte_val);
      sum_d = sum_q + head.byte_val;
    end
    if (head.clr) begin
      crc_d = '0; sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; out_v_q <= 1'b0;
      crc_q <= '0; sum_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop) begin
        rp_q <= rp_q + 2'd1;
        crc_q <= crc_d; sum_q <= sum_d;
      end
      cnt_q <= cnt_q + {2'b00, push_i} - {2'b00, pop};
      if (pop) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) fifo_q[wp_q] <= push_cmd_i;
    if (pop) out_q <= res;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

// ----- sv/xmodem_crc_sender.sv -----
// top level of the xmodem crc sender
// Usage: every input word (file byte, received line byte, read timeout,
// transmit slot, start session) produces exactly one result word carrying
// the byte to send in that slot (if any), the fill request flag and the
// transfer status. Both channels are valid/ready.
// A taken word's result passes the packet store read register and then the
// command queue into the output register.
// Throughput: one word per cycle while the receiver keeps up; the sequencer
// decides each word combinationally and the check unit folds one data byte per cycle.
// When the receiver stalls, the four-entry command queue fills and in_ready_o
// drops until room is free again; no word is lost.
// Reset clears the sequencer, queue and accumulators and loads the limit
// registers with their defaults; the packet store is not cleared, a start
// session word clears the sequencer and accumulators but not the queue or limits.
// Limit registers sit on the apb port at byte addresses 0, 4, 8 and 12.
`default_nettype none
module xmodem_crc_sender #(
  parameter int unsigned MaxBlockBytes = xcs_pkg::MaxBlockBytes
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire xcs_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output xcs_pkg::out_item_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import xcs_pkg::*;

  cfg_t       cfg_q;
  logic       push;
  cmd_t       push_cmd;
  logic [2:0] fifo_cnt;
  reg_e       sel;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_try_limit <= 8'd30;
      cfg_q.retry_limit    <= 8'd30;
      cfg_q.ack_read_limit <= 8'd200;
      cfg_q.eot_try_limit  <= 8'd30;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        RegSyncTry: cfg_q.sync_try_limit <= pwdata[7:0];
        RegRetry:   cfg_q.retry_limit    <= pwdata[7:0];
        RegAckRead: cfg_q.ack_read_limit <= pwdata[7:0];
        RegEotTry:  cfg_q.eot_try_limit  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegSyncTry: prdata = {24'h0, cfg_q.sync_try_limit};
      RegRetry:   prdata = {24'h0, cfg_q.retry_limit};
      RegAckRead: prdata = {24'h0, cfg_q.ack_read_limit};
      RegEotTry:  prdata = {24'h0, cfg_q.eot_try_limit};
      default:    prdata = 32'h0;
    endcase
  end

  xcs_front #(.MaxBlockBytes(MaxBlockBytes)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .fifo_cnt_i (fifo_cnt),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  xcs_back u_back (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .fifo_cnt_o (fifo_cnt),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );
endmodule
`default_nettype wire

// ----- bench/xcs_checker.sv -----
// checker for the xmodem crc sender: predicts each result word and compares
module xcs_checker
  import xcs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_item_t out_data_i,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_val_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] lim_sync, lim_retry, lim_ack, lim_eot;
  phase_e     ph;
  logic [7:0] store [MaxBlockBytes];
  int unsigned fill, sidx;
  logic [7:0] blk_no, sum_a, tries, reads;
  logic [15:0] crc_a;
  bit         long_blk, sum_md, eof_seen;
  out_item_t  expected_words[$];

  assign pending_o = expected_words.size();

  function automatic int unsigned blen();
    return long_blk ? 1024 : 128;
  endfunction

  function automatic bit at_eot();
    return eof_seen && fill == 0;
  endfunction

  task automatic clear_xfer();
    ph = PhSync; fill = 0; sidx = 0; blk_no = 8'd1; crc_a = '0; sum_a = '0;
    tries = '0; reads = '0; long_blk = 0; sum_md = 0; eof_seen = 0;
  endtask

  task automatic start_frame();
    ph = PhSend; sidx = 0; crc_a = '0; sum_a = '0;
  endtask

  // crc-16 ccitt, msb first, and the arithmetic checksum
  task automatic fold(input logic [7:0] b);
    logic [15:0] c;
    c = crc_a ^ {b, 8'h00};
    sum_a = sum_a + b;
    for (int k = 0; k < 8; k++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    crc_a = c;
  endtask

  task automatic predict_word(input in_item_t it);
    out_item_t r;
    bit eot, failed, is_line;
    int unsigned ln, last, d;
    logic [7:0] v;
    r = '0;
    is_line = it.operation == OpLine || it.operation == OpTmo;
    if (it.operation == OpStart) begin
      clear_xfer();
    end else if (it.operation == OpFile && ph == PhFill) begin
      if (fill < MaxBlockBytes) store[fill] = it.data_byte;
      fill++;
      if (it.end_of_file) eof_seen = 1;
      if (it.end_of_file || fill >= blen()) start_frame();
    end else if (is_line && ph == PhSync) begin
      if (reads != 8'd255) reads++;
      if (it.operation == OpLine && it.data_byte == BNak) begin
        sum_md = 1; long_blk = 0; fill = 0; ph = PhFill;
      end else if (it.operation == OpLine && it.data_byte == BC) begin
        sum_md = 0; ph = PhKwait;
      end else if (reads >= lim_sync) begin
        ph = PhFail;
      end
    end else if (is_line && ph == PhKwait) begin
      long_blk = it.operation == OpLine && it.data_byte == BK && MaxBlockBytes >= 1024;
      fill = 0; ph = PhFill;
    end else if (is_line && ph == PhWait) begin
      eot = at_eot();
      failed = 0;
      if (reads != 8'd255) reads++;
      if (it.operation == OpLine && it.data_byte == BAck) begin
        tries = '0;
        if (eot) ph = PhDone;
        else begin
          blk_no++; fill = 0;
          if (eof_seen) start_frame();
          else ph = PhFill;
        end
      end else if (it.operation == OpLine &&
                   (it.data_byte == BNak || it.data_byte == BC || it.data_byte == BCan)) begin
        failed = 1;
      end else if (reads >= lim_ack) begin
        failed = 1;
      end
      if (failed) begin
        if (tries != 8'd255) tries++;
        if (tries >= (eot ? lim_eot : lim_retry)) ph = PhFail;
        else start_frame();
      end
    end else if (it.operation == OpSlot && ph == PhSend) begin
      r.tx_valid = 1;
      if (at_eot()) begin
        r.tx_byte = BEot; ph = PhWait; reads = '0;
      end else begin
        ln = blen();
        last = 3 + ln + (sum_md ? 0 : 1);
        if (sidx == 0) r.tx_byte = long_blk ? BStx : BSoh;
        else if (sidx == 1) r.tx_byte = blk_no;
        else if (sidx == 2) r.tx_byte = ~blk_no;
        else if (sidx < 3 + ln) begin
          d = sidx - 3;
          v = (d < fill && d < MaxBlockBytes) ? store[d] : 8'h00;
          fold(v);
          r.tx_byte = v;
        end else if (sum_md) r.tx_byte = sum_a;
        else if (sidx == 3 + ln) r.tx_byte = crc_a[15:8];
        else r.tx_byte = crc_a[7:0];
        if (sidx >= last) begin
          ph = PhWait; reads = '0;
        end else begin
          sidx = (sidx + 1) & 11'h7ff;
        end
      end
    end
    r.need_data = ph == PhFill;
    r.status = ph == PhDone ? 2'd1 : (ph >= PhFail ? 2'd2 : 2'd0);
    expected_words.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      lim_sync = 8'd30; lim_retry = 8'd30; lim_ack = 8'd200; lim_eot = 8'd30;
      clear_xfer();
      expected_words.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSyncTry: lim_sync = cfg_val_i;
          RegRetry:   lim_retry = cfg_val_i;
          RegAckRead: lim_ack = cfg_val_i;
          default:    lim_eot = cfg_val_i;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_words.pop_front();
          if (e !== out_data_i) begin
            if (e.tx_valid !== out_data_i.tx_valid)
              $error("tx_valid exp %0d got %0d", e.tx_valid, out_data_i.tx_valid);
            if (e.tx_byte !== out_data_i.tx_byte)
              $error("tx_byte exp %0h got %0h", e.tx_byte, out_data_i.tx_byte);
            if (e.need_data !== out_data_i.need_data)
              $error("need_data exp %0d got %0d", e.need_data, out_data_i.need_data);
            if (e.status !== out_data_i.status)
              $error("status exp %0d got %0d", e.status, out_data_i.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_word(in_data_i);
    end
  end
endmodule

// ----- bench/testbench.sv -----
// stimulus and verdict for the xmodem crc sender
module testbench;
  import xcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int fails, pending, idle_cycles;
  bit cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_val;
  bit rx_free;
  int rx_wait;

  always #6 clk_i = ~clk_i;

  xmodem_crc_sender i_dut (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];
  assign cfg_val = pwdata[7:0];

  xcs_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_val_i(cfg_val),
    .fail_count_o(fails), .pending_o(pending)
  );

  // receiver drops ready for a random wait after each word it takes, unless rx_free holds it high
  always @(posedge clk_i) begin
    int w;
    if (rx_free) out_ready <= 1;
    else if (out_ready) begin
      if (out_valid) begin
        w = $urandom_range(0, 6);
        rx_wait <= w;
        out_ready <= (w == 0);
      end
    end else if (rx_wait > 1) rx_wait <= rx_wait - 1;
    else out_ready <= 1;
  end

  always @(posedge clk_i) begin
    if (in_valid && in_ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays high after an accept unless a gap follows
  task automatic send_word(input op_e op, input logic [7:0] b, input bit eof, input bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 6) : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1;
    in_data <= '{operation: op, data_byte: b, end_of_file: eof};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_limit(input reg_e r, input logic [7:0] v);
    in_valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= {24'($urandom()), v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one session: sync, a random file, random acknowledges
  task automatic session(input int nbytes, input bit gaps);
    int r;
    send_word(OpStart, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), gaps);
    r = $urandom_range(0, 9);
    if (r < 4) send_word(OpLine, BNak, 0, gaps);
    else begin
      send_word(OpLine, BC, 0, gaps);
      send_word(OpLine, (r < 6) ? BK : 8'($urandom_range(0, 255)), 0, gaps);
    end
    for (int i = 0; i < nbytes; i++) begin
      send_word(OpFile, 8'($urandom_range(0, 255)), i == nbytes - 1, gaps);
      if ($urandom_range(0, 15) == 0)
        send_word(op_e'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), gaps);
      if ($urandom_range(0, 40) == 0) begin
        // a short burst of slots and line noise
        repeat (3) send_word(OpSlot, 0, 0, gaps);
        send_word(($urandom_range(0, 1) ? OpLine : OpTmo), 8'($urandom_range(0, 255)), 0,
                  gaps);
      end
    end
    repeat (12) send_word(OpSlot, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), gaps);
    r = $urandom_range(0, 3);
    send_word(r == 0 ? OpTmo : OpLine, r == 1 ? BNak : BAck, 0, gaps);
    repeat (3) send_word(OpSlot, 0, 0, gaps);
    send_word(OpLine, BAck, 0, gaps);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    rx_free = 1;
    // directed: sync failure paths and extremes
    send_word(OpTmo, 8'hff, 1, 0);
    send_word(OpLine, 8'h00, 0, 0);
    send_word(OpLine, BC, 0, 0);
    send_word(OpTmo, 0, 0, 0);
    send_word(OpFile, 8'hff, 0, 0);
    send_word(OpFile, 8'h00, 1, 0);
    send_word(OpSlot, 0, 0, 0);
    send_word(OpSlot, 0, 0, 0);
    send_word(OpLine, BCan, 0, 0);
    send_word(op_e'(3'd5), 8'h55, 0, 0);
    send_word(op_e'(3'd7), 8'haa, 1, 0);
    send_word(OpStart, 0, 0, 0);
    write_limit(RegSyncTry, 8'd1);
    send_word(OpTmo, 0, 0, 0);
    send_word(OpStart, 0, 0, 0);
    write_limit(RegSyncTry, 8'd255);
    write_limit(RegRetry, 8'd1);
    write_limit(RegAckRead, 8'd1);
    write_limit(RegEotTry, 8'd1);
    rx_free = 0;
    for (int s = 0; s < 8; s++) session($urandom_range(1, 40), 1);
    write_limit(RegRetry, 8'd255);
    write_limit(RegAckRead, 8'd255);
    write_limit(RegEotTry, 8'd255);
    write_limit(RegSyncTry, 8'd3);
    for (int s = 0; s < 6; s++) session($urandom_range(1, 60), s[0]);
    write_limit(RegAckRead, 8'd2);
    write_limit(RegRetry, 8'd4);
    write_limit(RegEotTry, 8'd2);
    session(130, 1);
    for (int s = 0; s < 5; s++) session($urandom_range(1, 30), 1);
    in_valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/xcs_pkg.sv
sv/xcs_ram.sv
sv/xcs_front.sv
sv/xcs_back.sv
sv/xmodem_crc_sender.sv
bench/xcs_checker.sv
bench/testbench.sv
